@@ hdl/qdsk_pkg.sv @@
package qdsk_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 12;
    localparam int FRAC_W     = 16;
    localparam int SUM_W      = COORD_W + 2;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int EYE_W      = ACC_W - COEF_FRAC;
    localparam int DIVIDEND_W = EYE_W + FRAC_W;
    localparam int MAT_W      = 4 * COEF_W;
    localparam int VIEW_W     = 3 * COEF_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [COORD_W-1:0] KEY_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] KEY_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_COL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_COL1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_COL2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAT_COL3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR = 3'd4;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [EYE_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hdl/qdsk_div.sv @@
// Radix-2 restoring divider, signed, truncating toward zero, result
// saturated to 32 bits. Divisor must be nonzero.
module qdsk_div (
    input  logic                clk,
    input  logic                rst_n,
    input  qdsk_pkg::div_req_t  req,
    output qdsk_pkg::div_rsp_t  rsp
);

    localparam int DW    = qdsk_pkg::DIVIDEND_W;
    localparam int EW    = qdsk_pkg::EYE_W;
    localparam int CW    = qdsk_pkg::COORD_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [EW-1:0]    rem_reg;
    logic [DW-1:0]    quo_reg;
    logic [EW-1:0]    den_reg;
    logic [CW-1:0]    quot_reg;

    logic [DW-1:0]    num_mag;
    logic [EW-1:0]    den_mag;
    logic [EW:0]      shifted;
    logic [EW+1:0]    trial;
    logic             fits;
    logic [EW-1:0]    rem_next;
    logic [DW-1:0]    quo_next;
    logic             ovf_pos;
    logic             ovf_neg;
    logic [CW-1:0]    sat_next;

    always_comb
    begin
        num_mag  = req.dividend[DW-1] ? (~req.dividend + 1'b1) : req.dividend;
        den_mag  = req.divisor[EW-1] ? (~req.divisor + 1'b1) : req.divisor;
        shifted  = {rem_reg, quo_reg[DW-1]};
        trial    = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !trial[EW+1];
        rem_next = fits ? trial[EW-1:0] : shifted[EW-1:0];
        quo_next = {quo_reg[DW-2:0], fits};
        // magnitude limits: 2^31 - 1 when positive, 2^31 when negative
        ovf_pos  = |quo_reg[DW-1:CW-1];
        ovf_neg  = (|quo_reg[DW-1:CW]) || (quo_reg[CW-1] && (|quo_reg[CW-2:0]));
        if (neg_reg)
        begin
            sat_next = ovf_neg ? qdsk_pkg::KEY_MIN : (~quo_reg[CW-1:0] + 1'b1);
        end
        else
        begin
            sat_next = ovf_pos ? qdsk_pkg::KEY_MAX : quo_reg[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_W'(DW))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[DW-1] ^ req.divisor[EW-1];
            rem_reg <= '0;
            quo_reg <= num_mag;
            den_reg <= den_mag;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(DW))
            begin
                quot_reg <= sat_next;
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

@@ hdl/quad_depth_sort_key.sv @@
// Painter's-sort depth key for quads. Vertices (Q16.16) are taken one per
// transfer and summed; the fourth vertex of each quad starts the key
// computation and in_ready stays low until it is done. The centroid goes
// through the 4x4 column-major matrix (Q4.12), eye x/y/z are divided by eye w
// and dotted with the view direction. All products share one 32x16
// multiplier (12 for the matrix, 3 for the dot) and the three divides share
// one 54-step radix-2 divider. When eye w is zero the divides and the dot
// are skipped, the key saturates to the largest value and w_was_zero is
// set. The key computation ends by waiting for the output register to be
// free. Vertices 1 to 3 are accepted without a stall. The finished result
// sits in an output register; the next quad's vertices are accepted while
// it waits.
module quad_depth_sort_key (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [qdsk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qdsk_pkg::MAT_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [qdsk_pkg::COORD_W-1:0]   vertex_x,
    input  logic signed [qdsk_pkg::COORD_W-1:0]   vertex_y,
    input  logic signed [qdsk_pkg::COORD_W-1:0]   vertex_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [qdsk_pkg::COORD_W-1:0]   depth_key,
    output logic                                  before_previous,
    output logic                                  w_was_zero
);

    localparam int CW  = qdsk_pkg::COORD_W;
    localparam int KW  = qdsk_pkg::COEF_W;
    localparam int SW  = qdsk_pkg::SUM_W;
    localparam int PW  = qdsk_pkg::PROD_W;
    localparam int AW  = qdsk_pkg::ACC_W;
    localparam int EW  = qdsk_pkg::EYE_W;
    localparam int FW  = qdsk_pkg::FRAC_W;
    localparam int QF  = qdsk_pkg::COEF_FRAC;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAT_MUL,
        ST_MAT_ACC,
        ST_W_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [qdsk_pkg::MAT_W-1:0]  mat_col_reg [3];
    logic [qdsk_pkg::MAT_W-1:0]  mat_trans_reg;
    logic [qdsk_pkg::VIEW_W-1:0] view_reg;

    logic signed [SW-1:0]    sum_x_reg;
    logic signed [SW-1:0]    sum_y_reg;
    logic signed [SW-1:0]    sum_z_reg;
    logic [1:0]              vcount_reg;
    logic signed [CW-1:0]    c_reg [3];
    logic signed [EW-1:0]    eye_reg [4];
    logic signed [CW-1:0]    q_reg [3];
    logic [1:0]              row_reg;
    logic [1:0]              col_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [AW-1:0]    acc_reg;
    logic [CW-1:0]           key_reg;
    logic                    wzero_reg;
    logic signed [CW-1:0]    prev_key_reg;
    logic                    have_prev_reg;

    logic                    out_valid_reg;
    logic signed [CW-1:0]    depth_key_reg;
    logic                    before_prev_reg;
    logic                    w_zero_out_reg;

    logic signed [SW-1:0]    sum_x_next;
    logic signed [SW-1:0]    sum_y_next;
    logic signed [SW-1:0]    sum_z_next;
    logic                    in_xfer;
    logic signed [CW-1:0]    mul_a;
    logic signed [KW-1:0]    mul_b;
    logic signed [PW-1:0]    prod_next;
    logic signed [KW-1:0]    trans;
    logic signed [AW-1:0]    acc_base;
    logic signed [AW-1:0]    acc_next;
    logic signed [EW-1:0]    acc_q;
    logic                    key_ovf_pos;
    logic                    key_ovf_neg;
    logic [CW-1:0]           key_sat;
    logic                    mat_phase;

    qdsk_pkg::div_req_t      div_req;
    qdsk_pkg::div_rsp_t      div_rsp;

    qdsk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        in_xfer    = in_valid && in_ready;
        sum_x_next = sum_x_reg + SW'(vertex_x);
        sum_y_next = sum_y_reg + SW'(vertex_y);
        sum_z_next = sum_z_reg + SW'(vertex_z);

        mat_phase = (state_reg == ST_MAT_MUL) || (state_reg == ST_MAT_ACC);
        if (mat_phase)
        begin
            mul_a = c_reg[col_reg];
            mul_b = mat_col_reg[col_reg][{row_reg, 4'b0000} +: KW];
        end
        else
        begin
            mul_a = q_reg[col_reg];
            mul_b = view_reg[{col_reg, 4'b0000} +: KW];
        end
        prod_next = mul_a * mul_b;

        // translation column times w = 1, aligned to Q.28
        trans    = mat_trans_reg[{row_reg, 4'b0000} +: KW];
        acc_base = (col_reg != 2'd0) ? acc_reg
                 : (mat_phase ? {{(AW-KW-FW){trans[KW-1]}}, trans, {FW{1'b0}}} : '0);
        acc_next = acc_base + AW'(prod_reg);
        acc_q    = acc_next[AW-1:QF];

        key_ovf_pos = !acc_q[EW-1] && (|acc_q[EW-2:CW-1]);
        key_ovf_neg = acc_q[EW-1] && !(&acc_q[EW-2:CW-1]);
        if (key_ovf_pos)
        begin
            key_sat = qdsk_pkg::KEY_MAX;
        end
        else if (key_ovf_neg)
        begin
            key_sat = qdsk_pkg::KEY_MIN;
        end
        else
        begin
            key_sat = acc_q[CW-1:0];
        end

        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = {eye_reg[col_reg], {FW{1'b0}}};
        div_req.divisor  = eye_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mat_col_reg     <= '{default: '0};
            mat_trans_reg   <= '0;
            view_reg        <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_z_reg       <= '0;
            vcount_reg      <= '0;
            c_reg           <= '{default: '0};
            eye_reg         <= '{default: '0};
            q_reg           <= '{default: '0};
            row_reg         <= '0;
            col_reg         <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            key_reg         <= '0;
            wzero_reg       <= 1'b0;
            prev_key_reg    <= '0;
            have_prev_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            depth_key_reg   <= '0;
            before_prev_reg <= 1'b0;
            w_zero_out_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    qdsk_pkg::CFG_MAT_COL0: mat_col_reg[0] <= cfg_data;
                    qdsk_pkg::CFG_MAT_COL1: mat_col_reg[1] <= cfg_data;
                    qdsk_pkg::CFG_MAT_COL2: mat_col_reg[2] <= cfg_data;
                    qdsk_pkg::CFG_MAT_COL3: mat_trans_reg  <= cfg_data;
                    qdsk_pkg::CFG_VIEW_DIR: view_reg <= cfg_data[qdsk_pkg::VIEW_W-1:0];
                    default: ;
                endcase
            end

            // in ST_FINISH a taken result is replaced by the new one below
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (vcount_reg == 2'd3)
                        begin
                            // centroid: floor of sum / 4
                            c_reg[0]   <= sum_x_next[SW-1:2];
                            c_reg[1]   <= sum_y_next[SW-1:2];
                            c_reg[2]   <= sum_z_next[SW-1:2];
                            sum_x_reg  <= '0;
                            sum_y_reg  <= '0;
                            sum_z_reg  <= '0;
                            vcount_reg <= '0;
                            row_reg    <= '0;
                            col_reg    <= '0;
                            state_reg  <= ST_MAT_MUL;
                        end
                        else
                        begin
                            sum_x_reg  <= sum_x_next;
                            sum_y_reg  <= sum_y_next;
                            sum_z_reg  <= sum_z_next;
                            vcount_reg <= vcount_reg + 1'b1;
                        end
                    end
                end
                ST_MAT_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_MAT_ACC;
                end
                ST_MAT_ACC:
                begin
                    acc_reg <= acc_next;
                    if (col_reg == 2'd2)
                    begin
                        eye_reg[row_reg] <= acc_q;
                        col_reg          <= '0;
                        if (row_reg == 2'd3)
                        begin
                            state_reg <= ST_W_CHECK;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= ST_MAT_MUL;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_MAT_MUL;
                    end
                end
                ST_W_CHECK:
                begin
                    col_reg <= '0;
                    if (eye_reg[3] == '0)
                    begin
                        key_reg   <= qdsk_pkg::KEY_MAX;
                        wzero_reg <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        wzero_reg <= 1'b0;
                        state_reg <= ST_DIV_START;
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        q_reg[col_reg] <= div_rsp.quotient;
                        if (col_reg == 2'd2)
                        begin
                            col_reg   <= '0;
                            state_reg <= ST_DOT_MUL;
                        end
                        else
                        begin
                            col_reg   <= col_reg + 1'b1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_DOT_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_DOT_ACC;
                end
                ST_DOT_ACC:
                begin
                    acc_reg <= acc_next;
                    if (col_reg == 2'd2)
                    begin
                        key_reg   <= key_sat;
                        col_reg   <= '0;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_DOT_MUL;
                    end
                end
                ST_FINISH:
                begin
                    // wait for the output register to be free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        depth_key_reg   <= key_reg;
                        before_prev_reg <= have_prev_reg && ($signed(key_reg) < prev_key_reg);
                        w_zero_out_reg  <= wzero_reg;
                        prev_key_reg    <= key_reg;
                        have_prev_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign depth_key       = depth_key_reg;
    assign before_previous = before_prev_reg;
    assign w_was_zero      = w_zero_out_reg;

endmodule

@@ bench/tb.sv @@
module tb;
    import qdsk_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] key;
        logic                      earlier;
        logic                      wzero;
    } depth_result_t;

    // Predicts the depth key of each quad from the vertices as they are
    // transferred, and holds the keys still owed by the block.
    class depth_key_tracker;
        logic [MAT_W-1:0]  column [4];
        logic [VIEW_W-1:0] view;
        longint            acc_x;
        longint            acc_y;
        longint            acc_z;
        int unsigned       corners;
        longint            last_key;
        bit                seen_quad;
        depth_result_t     keys_due [$];
        int unsigned       key_faults;

        function new();
            foreach (column[i])
                column[i] = '0;
            view       = '0;
            acc_x      = 0;
            acc_y      = 0;
            acc_z      = 0;
            corners    = 0;
            last_key   = 0;
            seen_quad  = 1'b0;
            key_faults = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAT_W-1:0] data);
            case (idx)
                CFG_MAT_COL0: column[0] = data;
                CFG_MAT_COL1: column[1] = data;
                CFG_MAT_COL2: column[2] = data;
                CFG_MAT_COL3: column[3] = data;
                CFG_VIEW_DIR: view = data[VIEW_W-1:0];
                default: ;
            endcase
        endfunction

        static function longint coef(logic [MAT_W-1:0] word, int r);
            logic signed [COEF_W-1:0] e;
            e = word[COEF_W*r +: COEF_W];
            return longint'(e);
        endfunction

        static function longint clamp32(longint v);
            if (v > longint'(KEY_MAX))
                return longint'(KEY_MAX);
            if (v < longint'($signed(KEY_MIN)))
                return longint'($signed(KEY_MIN));
            return v;
        endfunction

        function void flag(string what);
            key_faults++;
            if (key_faults <= 10)
                $display("%s", what);
        endfunction

        function void take_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                  logic signed [COORD_W-1:0] z);
            longint        cen [3];
            longint        eye [4];
            longint        dot;
            longint        key;
            bit            wzero;
            depth_result_t res;
            acc_x += longint'(x);
            acc_y += longint'(y);
            acc_z += longint'(z);
            if (corners < 3)
            begin
                corners++;
                return;
            end
            // centroid is a floor shift of the 34-bit sums
            cen[0]  = acc_x >>> 2;
            cen[1]  = acc_y >>> 2;
            cen[2]  = acc_z >>> 2;
            acc_x   = 0;
            acc_y   = 0;
            acc_z   = 0;
            corners = 0;
            for (int r = 0; r < 4; r++)
                eye[r] = (cen[0] * coef(column[0], r) + cen[1] * coef(column[1], r)
                          + cen[2] * coef(column[2], r) + 65536 * coef(column[3], r))
                         >>> COEF_FRAC;
            wzero = (eye[3] == 0);
            if (wzero)
                key = longint'(KEY_MAX);
            else
            begin
                dot = 0;
                // integer divide truncates toward zero
                for (int r = 0; r < 3; r++)
                    dot += clamp32((eye[r] * 65536) / eye[3]) * coef(MAT_W'(view), r);
                key = clamp32(dot >>> COEF_FRAC);
            end
            res.key     = key[COORD_W-1:0];
            res.earlier = seen_quad && (key < last_key);
            res.wzero   = wzero;
            keys_due.push_back(res);
            last_key  = key;
            seen_quad = 1'b1;
        endfunction

        function void match_key(logic signed [COORD_W-1:0] key, logic earlier, logic wzero);
            depth_result_t want;
            if (keys_due.size() == 0)
            begin
                flag($sformatf("unexpected key transfer: key %0d earlier %b wzero %b",
                               key, earlier, wzero));
                return;
            end
            want = keys_due.pop_front();
            if (want.key !== key || want.earlier !== earlier || want.wzero !== wzero)
                flag($sformatf("key mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                               $signed(want.key), want.earlier, want.wzero,
                               key, earlier, wzero));
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [MAT_W-1:0]            cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [COORD_W-1:0]   vertex_x = '0;
    logic signed [COORD_W-1:0]   vertex_y = '0;
    logic signed [COORD_W-1:0]   vertex_z = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [COORD_W-1:0]   depth_key;
    logic                        before_previous;
    logic                        w_was_zero;

    depth_key_tracker trk;
    int unsigned      burst_left = 0;
    bit               steady_send = 1'b0;
    int unsigned      rx_hold = 0;

    quad_depth_sort_key uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .vertex_z        (vertex_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .depth_key       (depth_key),
        .before_previous (before_previous),
        .w_was_zero      (w_was_zero)
    );

    always #2 clk = ~clk;

    // receiver: alternating ready and stall stretches, occasionally a long open window
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            out_ready <= !out_ready;
            if (out_ready)
                rx_hold <= $urandom_range(1, 24);
            else
                rx_hold <= ($urandom_range(0, 3) == 0) ? 400 : $urandom_range(1, 30);
        end
        else
            rx_hold <= rx_hold - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            trk.match_key(depth_key, before_previous, w_was_zero);
    end

    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z);
        int unsigned gap;
        in_valid <= 1'b1;
        vertex_x <= x;
        vertex_y <= y;
        vertex_z <= z;
        do
            @(posedge clk);
        while (!in_ready);
        trk.take_vertex(x, y, z);
        if (!steady_send && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else if (burst_left != 0)
            burst_left--;
    endtask

    task automatic send_quad_same(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic signed [COORD_W-1:0] z);
        repeat (4) send_vertex(x, y, z);
    endtask

    // hold off the sender until every owed key has been transferred
    task automatic drain();
        in_valid <= 1'b0;
        while (trk.keys_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MAT_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        trk.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic program_config(input logic [MAT_W-1:0] c0, input logic [MAT_W-1:0] c1,
                                  input logic [MAT_W-1:0] c2, input logic [MAT_W-1:0] c3,
                                  input logic [MAT_W-1:0] dir);
        reg_write(CFG_MAT_COL0, c0);
        reg_write(CFG_MAT_COL1, c1);
        reg_write(CFG_MAT_COL2, c2);
        reg_write(CFG_MAT_COL3, c3);
        reg_write(CFG_VIEW_DIR, dir);
        // unmapped indexes must leave the map alone
        for (int k = CFG_VIEW_DIR + 1; k < (1 << CFG_IDX_W); k++)
            reg_write(CFG_IDX_W'(k), {$urandom, $urandom});
        cfg_write <= 1'b0;
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] e;
        case ($urandom_range(0, 3))
            0: e = COEF_W'($urandom);
            1: e = COEF_W'($urandom_range(0, 16'h2000)) - 16'h1000;
            2: e = '0;
            default: e = 16'h1000;
        endcase
        return e;
    endfunction

    function automatic logic [MAT_W-1:0] rand_column();
        return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = COORD_W'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            3:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            4: v = KEY_MAX;
            default: v = KEY_MIN;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [MAT_W-1:0] col [4];
        trk = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset map is all zero, so eye w is zero; also the first quad
        send_vertex(KEY_MAX, KEY_MIN, 32'sd0);
        send_vertex(KEY_MIN, KEY_MAX, -32'sd1);
        send_vertex(32'sd0, 32'sd0, 32'sd0);
        send_vertex(32'sd1, -32'sd1, KEY_MAX);
        drain();

        // identity map, key follows centroid z
        program_config(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                       64'h0000_1000_0000_0000, 64'h1000_0000_0000_0000,
                       64'h0000_1000_0000_0000);
        send_quad_same(KEY_MAX, KEY_MAX, KEY_MAX);
        send_quad_same(KEY_MIN, KEY_MIN, KEY_MIN);
        // floor rounding of a negative centroid
        send_vertex(32'sd3, 32'sd0, -32'sd1);
        send_vertex(32'sd0, 32'sd0, 32'sd0);
        send_vertex(32'sd0, 32'sd0, 32'sd0);
        send_vertex(32'sd0, -32'sd1, 32'sd0);
        drain();

        // tiny w: quotient and dot product both saturate
        program_config(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                       64'h0000_1000_0000_0000, 64'h0001_0000_0000_0000,
                       64'h0000_7FFF_8000_7FFF);
        send_quad_same(KEY_MAX, KEY_MAX, KEY_MAX);
        drain();

        // w = z - 1.0: zero w with a live map, then negative w
        program_config(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000,
                       64'h1000_1000_0000_0000, 64'hF000_0000_0000_0000,
                       64'h0000_7FFF_8000_1000);
        send_quad_same(32'sh0000_1234, -32'sh0000_4321, 32'sh0001_0000);
        send_quad_same(32'sh4000_0000, KEY_MIN, 32'sd0);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0: program_config('1, '1, '1, '1, '1);
                1: program_config({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                                  {4{16'h7FFF}}, {4{16'h7FFF}});
                2: program_config({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                                  {4{16'h8000}}, {4{16'h8000}});
                default:
                begin
                    foreach (col[i])
                        col[i] = rand_column();
                    // no w row at all: every quad takes the zero-w path
                    if (phase == 3)
                        foreach (col[i])
                            col[i][MAT_W-1 -: COEF_W] = '0;
                    program_config(col[0], col[1], col[2], col[3], {$urandom, $urandom});
                end
            endcase
            steady_send = (phase % 4 == 1);
            repeat (32 * 4) send_vertex(rand_coord(), rand_coord(), rand_coord());
            drain();
        end

        repeat (300) @(posedge clk);
        if (trk.key_faults == 0 && trk.keys_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(4 * 800000);
        $display("Mismatches found");
        $finish;
    end

endmodule
